// ----- rtl/dhcm_pkg.sv -----
// Shared types and constants for the distance heat color map.
// Holds the divider word passed along the cell chain and the hue table builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dhcm_pkg;

    // Distance and register width
    localparam int DIST_BITS       = 20;
    // Hue table size and index width
    localparam int HUE_TABLE_DEPTH = 1024;
    localparam int HUE_ADDR_BITS   = $clog2(HUE_TABLE_DEPTH);
    // Q16 coldness ratio, 0..65536 needs one extra bit
    localparam int FRAC_BITS       = 16;
    localparam int QUO_BITS        = FRAC_BITS + 1;
    localparam int HUE_BITS        = FRAC_BITS + 1;
    // One divider cell per quotient bit
    localparam int DIV_CELLS       = QUO_BITS;

    // Word handed from one divider cell to the next
    typedef struct packed {
        logic                 beyond;   // distance above max, fixed color
        logic [DIST_BITS-1:0] divisor;  // effective max distance
        logic [DIST_BITS-1:0] rem;      // partial remainder, below divisor
        logic                 nbit;     // next numerator bit to shift in
        logic [QUO_BITS-1:0]  quo;      // quotient bits so far
    } t_div_word;

    typedef logic [HUE_BITS-1:0] t_hue_rom [HUE_TABLE_DEPTH];

    // Build the hue table: entry k is the largest h with
    // h^10 * (depth-1)^7 <= 2^160 * k^7, i.e. floor(65536 * (k/(depth-1))^0.7).
    function automatic t_hue_rom build_hue_rom();
        t_hue_rom     rom;
        logic [319:0] dpow;
        logic [319:0] rhs;
        logic [319:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        int           j;
        int           k;
        dpow = 320'd1;
        for (j = 0; j < 7; j++) begin
            dpow = dpow * 320'(HUE_TABLE_DEPTH - 1);
        end
        for (k = 0; k < HUE_TABLE_DEPTH; k++) begin
            rhs = 320'd1 << 160;
            for (j = 0; j < 7; j++) begin
                rhs = rhs * 320'(k);
            end
            lo = 0;
            hi = 1 << FRAC_BITS;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                lhs = dpow;
                for (j = 0; j < 10; j++) begin
                    lhs = lhs * 320'(mid);
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            rom[k] = HUE_BITS'(lo);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dhcm_div_cell.sv -----
// One cell of the restoring divider chain: retires one quotient bit per word.
// Depends on dhcm_pkg for the word type and widths.
`timescale 1ns / 1ps
`default_nettype none

module dhcm_div_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  dhcm_pkg::t_div_word  i_word,
    output logic                 o_valid,
    input  wire                  i_ready,
    output dhcm_pkg::t_div_word  o_word
);

    logic                          r_valid;
    dhcm_pkg::t_div_word           r_word;
    dhcm_pkg::t_div_word           n_word;
    logic [dhcm_pkg::DIST_BITS:0]  w_trial;
    logic [dhcm_pkg::DIST_BITS:0]  w_diff;
    logic                          w_ge;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        w_trial = {i_word.rem, i_word.nbit};
        w_ge    = (w_trial >= {1'b0, i_word.divisor});
        w_diff  = w_trial - {1'b0, i_word.divisor};
        n_word         = i_word;
        n_word.nbit    = 1'b0;
        n_word.rem     = w_ge ? w_diff[dhcm_pkg::DIST_BITS-1:0]
                              : w_trial[dhcm_pkg::DIST_BITS-1:0];
        n_word.quo     = {i_word.quo[dhcm_pkg::QUO_BITS-2:0], w_ge};
    end

    // Load when the slot is free or the neighbor takes the current word
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ----- rtl/dhcm_color.sv -----
// Color back end: hue table lookup, brightness, HSV-to-RGB and 8-bit scaling.
// Depends on dhcm_pkg for the divider word, widths and the hue table builder.
`timescale 1ns / 1ps
`default_nettype none

module dhcm_color (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  dhcm_pkg::t_div_word  i_word,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green
);

    localparam int STAGES     = 6;
    localparam int ADDR_BITS  = dhcm_pkg::HUE_ADDR_BITS;
    localparam int PROD_BITS  = dhcm_pkg::QUO_BITS + ADDR_BITS;
    localparam int HUE_BITS   = dhcm_pkg::HUE_BITS;
    localparam int FRAC_BITS  = dhcm_pkg::FRAC_BITS;
    localparam int VN_BITS    = 23;
    localparam int C_BITS     = FRAC_BITS + 1;
    localparam int N_BITS     = VN_BITS + C_BITS;
    localparam int X_BITS     = N_BITS + 5;
    localparam int Y_BITS     = X_BITS - 32;
    localparam int R5_BITS    = 12;
    localparam int QW_BITS    = Y_BITS + R5_BITS - 14;

    // Brightness numerators over 4915200 (= 75 * 2^16)
    localparam logic [VN_BITS-1:0]   VN_FULL      = VN_BITS'(4571136);
    localparam logic [VN_BITS-1:0]   VN_RAMP_BASE = VN_BITS'(2949120);
    localparam logic [VN_BITS-1:0]   VN_RAMP_STEP = VN_BITS'(200);
    localparam logic [HUE_BITS-1:0]  HUE_RAMP_MAX = HUE_BITS'(9830);
    localparam logic [C_BITS-1:0]    C_ONE        = C_BITS'(1) << FRAC_BITS;
    localparam logic [PROD_BITS-1:0] IDX_ROUND    = PROD_BITS'(1) << (FRAC_BITS - 1);
    // channel = floor((17*N + 5*2^31) / 2^32 / 5)
    localparam logic [X_BITS-1:0]    X_ROUND      = X_BITS'(5) << 31;
    localparam logic [R5_BITS-1:0]   RECIP_5      = R5_BITS'(3277);
    localparam logic [QW_BITS-1:0]   CHAN_MAX     = QW_BITS'(255);

    localparam dhcm_pkg::t_hue_rom HUE_ROM = dhcm_pkg::build_hue_rom();

    logic                   r_vld [STAGES];
    logic                   w_en  [STAGES];

    logic [ADDR_BITS-1:0]   r_addr;
    logic                   r_beyond0;
    logic [HUE_BITS-1:0]    r_hue;
    logic                   r_beyond1;
    logic [VN_BITS-1:0]     r_vn;
    logic [C_BITS-1:0]      r_rc;
    logic [C_BITS-1:0]      r_gc;
    logic [N_BITS-1:0]      r_nr;
    logic [N_BITS-1:0]      r_ng;
    logic [Y_BITS-1:0]      r_yr;
    logic [Y_BITS-1:0]      r_yg;
    logic [7:0]             r_red;
    logic [7:0]             r_green;

    logic [PROD_BITS-1:0]   w_idx;
    logic [VN_BITS-1:0]     n_vn;
    logic [C_BITS-1:0]      n_rc;
    logic [C_BITS-1:0]      n_gc;
    logic [HUE_BITS:0]      w_h2;
    logic [FRAC_BITS-1:0]   w_f;
    logic [X_BITS-1:0]      w_xr;
    logic [X_BITS-1:0]      w_xg;
    logic [QW_BITS-1:0]     w_qr;
    logic [QW_BITS-1:0]     w_qg;
    logic [Y_BITS+R5_BITS-1:0] w_pr;
    logic [Y_BITS+R5_BITS-1:0] w_pg;

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Table index: round u * (depth - 1) / 2^16 half up
    assign w_idx = PROD_BITS'(i_word.quo) * PROD_BITS'(dhcm_pkg::HUE_TABLE_DEPTH - 1)
                   + IDX_ROUND;

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_addr    <= w_idx[FRAC_BITS +: ADDR_BITS];
            r_beyond0 <= i_word.beyond;
        end
    end

    // Read the hue table
    always_ff @(posedge i_clk) begin
        if (w_en[1] && r_vld[0]) begin
            r_hue     <= HUE_ROM[r_addr];
            r_beyond1 <= r_beyond0;
        end
    end

    // Brightness and channel levels per hue sector
    always_comb begin
        w_h2 = {r_hue, 1'b0};
        w_f  = w_h2[FRAC_BITS-1:0];
        if (r_hue <= HUE_RAMP_MAX) begin
            n_vn = VN_RAMP_BASE + VN_BITS'(r_hue) * VN_RAMP_STEP;
        end else begin
            n_vn = VN_FULL;
        end
        case (w_h2[HUE_BITS:FRAC_BITS])
            2'd0: begin
                n_rc = C_ONE;
                n_gc = C_BITS'(w_f);
            end
            2'd1: begin
                n_rc = C_ONE - C_BITS'(w_f);
                n_gc = C_ONE;
            end
            default: begin
                n_rc = '0;
                n_gc = C_ONE;
            end
        endcase
        // Beyond max: dim red, no green
        if (r_beyond1) begin
            n_vn = VN_RAMP_BASE;
            n_rc = C_ONE;
            n_gc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2] && r_vld[1]) begin
            r_vn <= n_vn;
            r_rc <= n_rc;
            r_gc <= n_gc;
        end
    end

    // Scale levels by brightness
    always_ff @(posedge i_clk) begin
        if (w_en[3] && r_vld[2]) begin
            r_nr <= N_BITS'(r_vn) * N_BITS'(r_rc);
            r_ng <= N_BITS'(r_vn) * N_BITS'(r_gc);
        end
    end

    // Times 17 with rounding term, keep bits above 2^32
    assign w_xr = (X_BITS'(r_nr) << 4) + X_BITS'(r_nr) + X_ROUND;
    assign w_xg = (X_BITS'(r_ng) << 4) + X_BITS'(r_ng) + X_ROUND;

    always_ff @(posedge i_clk) begin
        if (w_en[4] && r_vld[3]) begin
            r_yr <= w_xr[X_BITS-1:32];
            r_yg <= w_xg[X_BITS-1:32];
        end
    end

    // Divide by five through the reciprocal, clamp to 8 bits
    assign w_pr = (Y_BITS + R5_BITS)'(r_yr) * (Y_BITS + R5_BITS)'(RECIP_5);
    assign w_pg = (Y_BITS + R5_BITS)'(r_yg) * (Y_BITS + R5_BITS)'(RECIP_5);
    assign w_qr = w_pr[Y_BITS+R5_BITS-1:14];
    assign w_qg = w_pg[Y_BITS+R5_BITS-1:14];

    always_ff @(posedge i_clk) begin
        if (w_en[5] && r_vld[4]) begin
            r_red   <= (w_qr > CHAN_MAX) ? 8'hFF : w_qr[7:0];
            r_green <= (w_qg > CHAN_MAX) ? 8'hFF : w_qg[7:0];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_red   = r_red;
    assign o_green = r_green;

endmodule

`default_nettype wire

// ----- rtl/distance_heat_color_map_core.sv -----
// Top level of the distance heat color map: input stage, divider cell chain
// and color back end. Depends on dhcm_pkg, dhcm_div_cell and dhcm_color.
// Registers from accepted word to result: 1 input stage, 17 divider cells at
//   one quotient bit each, 6 color stages.
// Throughput: one word per cycle unless the output stalls; each stage holds its own
//   word and moves when the next one is free, so bubbles close up under output stalls.
// Reset (synchronous, active low) empties all stages and sets max_distance to 1.
`timescale 1ns / 1ps
`default_nettype none

module distance_heat_color_map_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [19:0]  i_cfg_wdata,       // max_distance
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [23:0]  i_s_axis_tdata,    // [19:0] distance, [23:20] zero
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata     // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int DB    = dhcm_pkg::DIST_BITS;
    localparam int CELLS = dhcm_pkg::DIV_CELLS;

    logic [DB-1:0]        r_max_distance;
    logic                 r_prep_vld;
    dhcm_pkg::t_div_word  r_prep_word;
    dhcm_pkg::t_div_word  n_prep_word;
    logic [DB-1:0]        w_dist;
    logic [DB-1:0]        w_max;
    logic [DB-1:0]        w_diff;
    logic                 w_prep_en;

    logic                 w_vld   [CELLS+1];
    logic                 w_rdy   [CELLS+1];
    dhcm_pkg::t_div_word  w_word  [CELLS+1];

    logic [7:0]           w_red;
    logic [7:0]           w_green;

    // Hold the max distance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= DB'(1);
        end else if (i_cfg_we) begin
            r_max_distance <= i_cfg_wdata;
        end
    end

    // Compare and form the numerator; a zero max counts as one
    always_comb begin
        w_dist = i_s_axis_tdata[DB-1:0];
        w_max  = (r_max_distance == '0) ? DB'(1) : r_max_distance;
        n_prep_word.beyond  = (w_dist > w_max);
        w_diff              = n_prep_word.beyond ? '0 : (w_max - w_dist);
        n_prep_word.divisor = w_max;
        n_prep_word.rem     = w_diff >> 1;
        n_prep_word.nbit    = w_diff[0];
        n_prep_word.quo     = '0;
    end

    assign w_prep_en       = !r_prep_vld || w_rdy[0];
    assign o_s_axis_tready = w_prep_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else if (w_prep_en) begin
            r_prep_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prep_en && i_s_axis_tvalid) begin
            r_prep_word <= n_prep_word;
        end
    end

    assign w_vld[0]  = r_prep_vld;
    assign w_word[0] = r_prep_word;

    // Divider chain, one quotient bit per cell
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        dhcm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[c]),
            .o_ready (w_rdy[c]),
            .i_word  (w_word[c]),
            .o_valid (w_vld[c+1]),
            .i_ready (w_rdy[c+1]),
            .o_word  (w_word[c+1])
        );
    end

    dhcm_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[CELLS]),
        .o_ready (w_rdy[CELLS]),
        .i_word  (w_word[CELLS]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_red   (w_red),
        .o_green (w_green)
    );

    // Blue stays zero at full saturation
    assign o_m_axis_tdata = {8'h00, w_green, w_red};

endmodule

`default_nettype wire
